/* design/ter_pkg.sv */
// Shared types and constants of the triangle edge rasterizer.
`default_nettype none

package ter_pkg;

	// Vertex store and input codes.
	localparam int   NUM_SLOTS  = 3;
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Configuration register indexes and reset values.
	localparam logic        REG_SCREEN_WIDTH  = 1'b0;
	localparam logic        REG_SCREEN_HEIGHT = 1'b1;
	localparam logic [12:0] WIDTH_RESET       = 13'd640;
	localparam logic [12:0] HEIGHT_RESET      = 13'd480;
	localparam logic [12:0] SCREEN_MAX        = 13'd4096;

	// Divider: quotient bits produced one per cycle, enough for 255 * 32767.
	localparam int          DIV_STEPS  = 23;
	localparam int          CNT_W      = 5;
	localparam logic [15:0] DEPTH_BIAS = 16'h8000;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] d;
		logic signed [15:0] n;
	} ter_vtx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_vtx;
		logic cap_pixel;
		logic st_prod;
		logic st_edge;
		logic st_wprod;
		logic st_wsum;
		logic div_step;
		logic out_load;
		logic out_query;
	} ter_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic covered;
	} ter_sts_t;

endpackage

`default_nettype wire

/* design/ter_dp.sv */
// Datapath: vertex store, screen registers, edge functions, divider and output register.
`default_nettype none

module ter_dp import ter_pkg::*; #(
	parameter int FRAC_BITS = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [12:0]        cfg_data,
	input  wire ter_cmd_t           cmd,
	output ter_sts_t                sts,
	input  wire logic [1:0]         vertex_slot,
	input  wire logic signed [15:0] vert_x,
	input  wire logic signed [15:0] vert_y,
	input  wire logic signed [15:0] vert_depth,
	input  wire logic signed [15:0] vert_normal_z,
	input  wire logic [11:0]        pixel_x,
	input  wire logic [11:0]        pixel_y,
	output logic                    inside_res,
	output logic                    back_facing,
	output logic signed [15:0]      depth,
	output logic [7:0]              gray,
	output logic [11:0]             box_min_x,
	output logic [11:0]             box_min_y,
	output logic [11:0]             box_max_x,
	output logic [11:0]             box_max_y
);

	localparam int PW  = 13 + FRAC_BITS;
	localparam int PSW = PW + 1;
	localparam int DW  = ((PSW > 17) ? PSW : 17) + 1;
	localparam int PRW = DW + 18;
	localparam int EW  = PRW + 1;
	localparam int WPW = EW + 16;
	localparam int SW  = EW + 18;
	localparam int DVW = EW + DIV_STEPS;
	localparam int QW  = DIV_STEPS;

	ter_vtx_t          vtx_q [NUM_SLOTS];
	logic [12:0]       scr_w_q, scr_h_q;
	logic [PW-1:0]     px_q, py_q;

	logic signed [16:0]    x2 [NUM_SLOTS];
	logic signed [16:0]    y2 [NUM_SLOTS];
	logic signed [16:0]    ax [4], ay [4], bx [4], by [4];
	logic signed [DW-1:0]  pxs [4], pys [4];
	logic signed [17:0]    dxab [4], dyab [4];
	logic signed [DW-1:0]  dpx [4], dpy [4];
	logic signed [PRW-1:0] m1_s1 [4], m2_s1 [4];
	logic signed [EW-1:0]  w_s2 [4];
	logic signed [EW-1:0]  area_s3;
	logic                  covered_s3;
	logic signed [WPW-1:0] pd_s3 [NUM_SLOTS], pn_s3 [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  rej;
	logic signed [SW-1:0]  dsum, nsum;
	logic signed [DVW-1:0] nsum_ext;
	logic                  neg_q;
	logic [DVW-1:0]        rd_q, rg_q, dv_q;
	logic [QW-1:0]         qd_q, qg_q;
	logic                  ge_d, ge_g;

	logic signed [15:0] mnx, mny, mxx, mxy;
	logic [11:0]        lim_x, lim_y;

	// Screen size limit: zero acts as one, beyond the maximum as the maximum.
	function automatic logic [11:0] size_limit(input logic [12:0] size);
		logic [12:0] lim;
		if (size == 13'd0) begin
			lim = 13'd0;
		end else if (size > SCREEN_MAX) begin
			lim = SCREEN_MAX - 13'd1;
		end else begin
			lim = size - 13'd1;
		end
		return lim[11:0];
	endfunction

	// Integer part of a coordinate, clamped to the screen.
	function automatic logic [11:0] clamp_coord(input logic signed [15:0] v,
			input logic [11:0] lim);
		logic [15:0] c;
		c = v[15] ? 16'd0 : ($unsigned(v) >> FRAC_BITS);
		return (c > {4'd0, lim}) ? lim : c[11:0];
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= WIDTH_RESET;
			scr_h_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_SCREEN_WIDTH) begin
				scr_w_q <= cfg_data;
			end
			if (cfg_index == REG_SCREEN_HEIGHT) begin
				scr_h_q <= cfg_data;
			end
		end
	end

	// Vertex store; a load to the unused slot writes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				vtx_q[i] <= '0;
			end
		end else if (cmd.load_vtx && (vertex_slot < 2'(NUM_SLOTS))) begin
			vtx_q[vertex_slot] <= '{x: vert_x, y: vert_y, d: vert_depth, n: vert_normal_z};
		end
	end

	// Pixel centre in doubled coordinates.
	always_ff @(posedge clk) begin
		if (cmd.cap_pixel) begin
			px_q <= PW'({pixel_x, 1'b1}) << FRAC_BITS;
			py_q <= PW'({pixel_y, 1'b1}) << FRAC_BITS;
		end
	end

	// Edge lane operands: three pixel edges and the triangle area.
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			x2[i] = {vtx_q[i].x, 1'b0};
			y2[i] = {vtx_q[i].y, 1'b0};
		end
		ax[0] = x2[1]; ay[0] = y2[1]; bx[0] = x2[2]; by[0] = y2[2];
		ax[1] = x2[2]; ay[1] = y2[2]; bx[1] = x2[0]; by[1] = y2[0];
		ax[2] = x2[0]; ay[2] = y2[0]; bx[2] = x2[1]; by[2] = y2[1];
		ax[3] = x2[0]; ay[3] = y2[0]; bx[3] = x2[1]; by[3] = y2[1];
		for (int e = 0; e < 3; e++) begin
			pxs[e] = $signed({{(DW-PW){1'b0}}, px_q});
			pys[e] = $signed({{(DW-PW){1'b0}}, py_q});
		end
		pxs[3] = DW'(x2[2]);
		pys[3] = DW'(y2[2]);
		for (int e = 0; e < 4; e++) begin
			dxab[e] = 18'(ax[e]) - 18'(bx[e]);
			dyab[e] = 18'(ay[e]) - 18'(by[e]);
			dpx[e]  = pxs[e] - DW'(ax[e]);
			dpy[e]  = pys[e] - DW'(ay[e]);
		end
	end

	// Top-left rule: reject negative values, and zero on a right or bottom edge.
	always_comb begin
		for (int e = 0; e < NUM_SLOTS; e++) begin
			rej[e] = w_s2[e][EW-1] ||
				((w_s2[e] == '0) && (((dyab[e] == '0) && (dxab[e] >= 0)) || (dyab[e] > 0)));
		end
	end

	// Weighted sums of depth and normal z, and the divider comparisons.
	always_comb begin
		dsum     = SW'(pd_s3[0]) + SW'(pd_s3[1]) + SW'(pd_s3[2]);
		nsum     = SW'(pn_s3[0]) + SW'(pn_s3[1]) + SW'(pn_s3[2]);
		nsum_ext = DVW'(nsum);
		ge_d     = (rd_q >= dv_q);
		ge_g     = (rg_q >= dv_q);
	end

	// Edge function stages and restoring division.
	always_ff @(posedge clk) begin
		if (cmd.st_prod) begin
			for (int e = 0; e < 4; e++) begin
				m1_s1[e] <= dxab[e] * dpy[e];
				m2_s1[e] <= dyab[e] * dpx[e];
			end
		end
		if (cmd.st_edge) begin
			for (int e = 0; e < 4; e++) begin
				w_s2[e] <= EW'(m1_s1[e]) - EW'(m2_s1[e]);
			end
		end
		if (cmd.st_wprod) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				pd_s3[i] <= w_s2[i] * vtx_q[i].d;
				pn_s3[i] <= w_s2[i] * vtx_q[i].n;
			end
			area_s3    <= w_s2[3];
			covered_s3 <= (w_s2[3] > 0) && (rej == '0);
		end
		if (cmd.st_wsum) begin
			// Depth is biased so the floor division runs on a non-negative dividend.
			rd_q  <= DVW'(dsum) + (DVW'(area_s3) << 15);
			rg_q  <= (nsum_ext <<< 8) - nsum_ext;
			neg_q <= nsum[SW-1];
			dv_q  <= DVW'(area_s3) << (DIV_STEPS - 1);
			qd_q  <= '0;
			qg_q  <= '0;
		end
		if (cmd.div_step) begin
			if (ge_d) begin
				rd_q <= rd_q - dv_q;
			end
			if (ge_g) begin
				rg_q <= rg_q - dv_q;
			end
			qd_q <= {qd_q[QW-2:0], ge_d};
			qg_q <= {qg_q[QW-2:0], ge_g};
			dv_q <= dv_q >> 1;
		end
	end

	assign sts.covered = covered_s3;

	// Bounding box of the stored vertices.
	always_comb begin
		mnx = vtx_q[0].x; mxx = vtx_q[0].x;
		mny = vtx_q[0].y; mxy = vtx_q[0].y;
		for (int i = 1; i < NUM_SLOTS; i++) begin
			if (vtx_q[i].x < mnx) mnx = vtx_q[i].x;
			if (vtx_q[i].x > mxx) mxx = vtx_q[i].x;
			if (vtx_q[i].y < mny) mny = vtx_q[i].y;
			if (vtx_q[i].y > mxy) mxy = vtx_q[i].y;
		end
		lim_x = size_limit(scr_w_q);
		lim_y = size_limit(scr_h_q);
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			box_min_x <= clamp_coord(mnx, lim_x);
			box_max_x <= clamp_coord(mxx, lim_x);
			box_min_y <= clamp_coord(mny, lim_y);
			box_max_y <= clamp_coord(mxy, lim_y);
			if (cmd.out_query && covered_s3) begin
				inside_res  <= 1'b1;
				back_facing <= neg_q;
				depth       <= $signed(qd_q[15:0] ^ DEPTH_BIAS);
				gray        <= neg_q ? 8'd0 : qg_q[QW-1 -: 8];
			end else begin
				inside_res  <= 1'b0;
				back_facing <= 1'b0;
				depth       <= '0;
				gray        <= '0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/ter_ctrl.sv */
// Controller: sequences a load or a pixel query and owns the handshakes.
`default_nettype none

module ter_ctrl import ter_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     mode,
	output logic          out_valid,
	input  wire logic     out_ready,
	output ter_cmd_t      cmd,
	input  wire ter_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE, S_PROD, S_EDGE, S_WPROD, S_WSUM, S_DIV, S_FIN
	} state_t;

	state_t           state_q;
	logic             query_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Command decode.
	always_comb begin
		cmd.load_vtx  = accept && (mode == MODE_LOAD);
		cmd.cap_pixel = accept && (mode == MODE_QUERY);
		cmd.st_prod   = (state_q == S_PROD);
		cmd.st_edge   = (state_q == S_EDGE);
		cmd.st_wprod  = (state_q == S_WPROD);
		cmd.st_wsum   = (state_q == S_WSUM);
		cmd.div_step  = (state_q == S_DIV);
		cmd.out_load  = (state_q == S_FIN) && (!out_valid_q || out_ready);
		cmd.out_query = query_q;
	end

	// State, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			query_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						query_q <= mode;
						state_q <= (mode == MODE_QUERY) ? S_PROD : S_FIN;
					end
				end
				S_PROD:  state_q <= S_EDGE;
				S_EDGE:  state_q <= S_WPROD;
				S_WPROD: state_q <= S_WSUM;
				S_WSUM: begin
					cnt_q   <= CNT_W'(DIV_STEPS - 1);
					state_q <= sts.covered ? S_DIV : S_FIN;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/triangle_edge_rasterizer.sv */
// Top level of the triangle edge rasterizer.
//
//   channel   direction  handshake              contents
//   in        input      in_valid / in_ready    mode, vertex_slot, vertex fields, pixel
//   out       output     out_valid / out_ready  coverage, facing, depth, gray, box
//   cfg       input      cfg_we                 cfg_index, cfg_data (screen size)
//
// A vertex load goes straight to S_FIN. A pixel query steps through S_PROD, S_EDGE,
// S_WPROD and S_WSUM, then through S_DIV only when the pixel is covered, where the divider
// yields one quotient bit per cycle for the depth and gray quotients in parallel.
// A new item is taken once the previous result sits in the output register.
// Reset clears the vertex store to zero and the screen size to 640 by 480.
`default_nettype none

module triangle_edge_rasterizer import ter_pkg::*; #(
	parameter int FRAC_BITS = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [12:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               mode,
	input  wire logic [1:0]         vertex_slot,
	input  wire logic signed [15:0] vert_x,
	input  wire logic signed [15:0] vert_y,
	input  wire logic signed [15:0] vert_depth,
	input  wire logic signed [15:0] vert_normal_z,
	input  wire logic [11:0]        pixel_x,
	input  wire logic [11:0]        pixel_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    inside_res,
	output logic                    back_facing,
	output logic signed [15:0]      depth,
	output logic [7:0]              gray,
	output logic [11:0]             box_min_x,
	output logic [11:0]             box_min_y,
	output logic [11:0]             box_max_x,
	output logic [11:0]             box_max_y
);

	ter_cmd_t cmd;
	ter_sts_t sts;

	ter_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ter_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.vertex_slot   (vertex_slot),
		.vert_x        (vert_x),
		.vert_y        (vert_y),
		.vert_depth    (vert_depth),
		.vert_normal_z (vert_normal_z),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.inside_res    (inside_res),
		.back_facing   (back_facing),
		.depth         (depth),
		.gray          (gray),
		.box_min_x     (box_min_x),
		.box_min_y     (box_min_y),
		.box_max_x     (box_max_x),
		.box_max_y     (box_max_y)
	);

endmodule

`default_nettype wire

/* design/ter_chk.sv */
// Port checker for the triangle edge rasterizer and its bind.
`default_nettype none

module ter_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               inside_res,
	input wire logic               back_facing,
	input wire logic signed [15:0] depth,
	input wire logic [7:0]         gray,
	input wire logic [11:0]        box_min_x,
	input wire logic [11:0]        box_min_y,
	input wire logic [11:0]        box_max_x,
	input wire logic [11:0]        box_max_y
);

	// A waiting result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// A waiting result keeps its payload: depth, gray and the box minimum x are checked.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(depth) && $stable(gray) && $stable(box_min_x))
		else $error("result payload changed while stalled");

	// Clamping keeps the box ordered.
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (box_min_x <= box_max_x) && (box_min_y <= box_max_y))
		else $error("bounding box out of order");

	// An uncovered pixel carries no shading.
	a_uncovered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_res |-> !back_facing && (depth == 16'sd0) && (gray == 8'd0))
		else $error("shading on an uncovered pixel");

	// A back-facing pixel is covered and has no gray value.
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && back_facing |-> inside_res && (gray == 8'd0))
		else $error("back-facing result inconsistent");

endmodule

bind triangle_edge_rasterizer ter_chk u_ter_chk (.*);

`default_nettype wire
